>>> hdl/calendar_date_counter_core_macros.svh
`ifndef CALENDAR_DATE_COUNTER_CORE_MACROS_SVH
`define CALENDAR_DATE_COUNTER_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define CDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/cdc_pkg.sv
package cdc_pkg;

  localparam int unsigned YEAR_BITS = 14;
  localparam int unsigned SUM_BITS  = YEAR_BITS + 1;

  typedef logic [YEAR_BITS-1:0] year_t;

  localparam year_t      YEAR_MIN    = YEAR_BITS'(1900);
  localparam year_t      YEAR_MAX    = {YEAR_BITS{1'b1}};
  localparam year_t      RESET_YEAR  = YEAR_BITS'(2019);
  localparam logic [3:0] RESET_MONTH = 4'd1;
  localparam logic [4:0] RESET_DAY   = 5'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_MAR   = 4'd3;
  localparam logic [3:0] MONTH_DEC   = 4'd12;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_COMPARE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ORDER_EQUAL   = 2'd0,
    ORDER_LATER   = 2'd1,
    ORDER_EARLIER = 2'd2
  } order_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] month;
    logic [4:0] day;
    year_t      year;
  } req_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    year_t      year;
  } date_t;

  typedef struct packed {
    date_t  date;
    logic   ok;
    order_e order;
  } upd_t;

  typedef struct packed {
    date_t      date;
    logic [2:0] weekday;
    logic       ok;
    order_e     order;
  } rsp_t;

endpackage

>>> hdl/cdc_ifs.sv
interface cdc_req_if;
  import cdc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] in_month;
  logic [4:0] in_day;
  year_t      in_year;

  modport source (output valid, cmd, in_month, in_day, in_year, input ready);
  modport sink (input valid, cmd, in_month, in_day, in_year, output ready);
endinterface

interface cdc_rsp_if;
  import cdc_pkg::*;

  logic       valid;
  logic       ready;
  logic [3:0] cur_month;
  logic [4:0] cur_day;
  year_t      cur_year;
  logic [2:0] weekday;
  logic       ok;
  logic [1:0] order;

  modport source (output valid, cur_month, cur_day, cur_year, weekday, ok, order,
                  input ready);
  modport sink (input valid, cur_month, cur_day, cur_year, weekday, ok, order,
                output ready);
endinterface

>>> hdl/cdc_date_update.sv
`include "calendar_date_counter_core_macros.svh"

module cdc_date_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cdc_pkg::req_t req_i,
  output logic          upd_valid_o,
  input  logic          upd_ready_i,
  output cdc_pkg::upd_t upd_o
);
  import cdc_pkg::*;

  // A year is divisible by 25 exactly when its product with the inverse of 25
  // modulo 2^YEAR_BITS does not exceed the largest multiple count.
  function automatic int unsigned inv_mod_f(int unsigned a);
    int unsigned x;
    x = a;
    for (int i = 0; i < 4; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

  localparam year_t INV25     = year_t'(inv_mod_f(25));
  localparam year_t DIV25_LIM = year_t'(((1 << YEAR_BITS) - 1) / 25);

  function automatic logic is_leap(year_t y);
    year_t p;
    logic  div25;
    p     = year_t'(y * INV25);
    div25 = (p <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  logic       in_valid_q;
  req_t       in_q;
  logic       upd_valid_q;
  upd_t       upd_q;
  date_t      date_q;
  date_t      date_d;
  logic       ok_d;
  order_e     order_d;
  logic [4:0] cur_len;
  logic [4:0] in_len;
  logic       s1_ready;
  logic       load;

  assign s1_ready    = !upd_valid_q || upd_ready_i;
  assign req_ready_o = !in_valid_q || s1_ready;
  assign load        = in_valid_q && s1_ready;
  assign upd_valid_o = upd_valid_q;
  assign upd_o       = upd_q;

  assign cur_len = month_len(date_q.month, is_leap(date_q.year));
  assign in_len  = month_len(in_q.month, is_leap(in_q.year));

  always_comb begin
    date_d  = date_q;
    ok_d    = 1'b0;
    order_d = ORDER_EQUAL;
    case (in_q.cmd)
      CMD_SET: begin
        if (in_q.year >= YEAR_MIN && in_len != 5'd0 && in_q.day != 5'd0 &&
            in_q.day <= in_len) begin
          date_d = '{month: in_q.month, day: in_q.day, year: in_q.year};
          ok_d   = 1'b1;
        end
      end
      CMD_TICK: begin
        if (date_q.day < cur_len) begin
          date_d.day = date_q.day + 5'd1;
          ok_d       = 1'b1;
        end else if (date_q.month < MONTH_DEC) begin
          date_d.month = date_q.month + 4'd1;
          date_d.day   = RESET_DAY;
          ok_d         = 1'b1;
        end else if (date_q.year != YEAR_MAX) begin
          date_d = '{month: RESET_MONTH, day: RESET_DAY, year: date_q.year + year_t'(1)};
          ok_d   = 1'b1;
        end
      end
      CMD_COMPARE: begin
        ok_d = 1'b1;
        if (date_q.year != in_q.year) begin
          order_d = (date_q.year > in_q.year) ? ORDER_LATER : ORDER_EARLIER;
        end else if (date_q.month != in_q.month) begin
          order_d = (date_q.month > in_q.month) ? ORDER_LATER : ORDER_EARLIER;
        end else if (date_q.day != in_q.day) begin
          order_d = (date_q.day > in_q.day) ? ORDER_LATER : ORDER_EARLIER;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      upd_valid_q <= 1'b0;
      date_q      <= '{month: RESET_MONTH, day: RESET_DAY, year: RESET_YEAR};
    end else begin
      if (req_ready_o) begin
        in_valid_q <= req_valid_i;
      end
      if (s1_ready) begin
        upd_valid_q <= in_valid_q;
      end
      if (load) begin
        date_q <= date_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      in_q <= req_i;
    end
    if (load) begin
      upd_q <= '{date: date_d, ok: ok_d, order: order_d};
    end
  end

  `CDC_ASSERT(a_day_in_month, date_q.day != 5'd0 && date_q.day <= cur_len, "Stored date is not a calendar date.")
  `CDC_ASSERT(a_state_hold, !load |=> $stable(date_q), "Stored date changed without a request.")
  `CDC_ASSERT(a_reject_hold, load && !ok_d |=> $stable(date_q), "A refused request changed the date.")
  `CDC_ASSERT(a_order_ok, upd_valid_q && upd_q.order != ORDER_EQUAL |-> upd_q.ok, "Order given without ok.")

endmodule

>>> hdl/cdc_weekday.sv
`include "calendar_date_counter_core_macros.svh"

module cdc_weekday (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_valid_i,
  output logic          upd_ready_o,
  input  cdc_pkg::upd_t upd_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cdc_pkg::rsp_t rsp_o
);
  import cdc_pkg::*;

  localparam int unsigned Q4_BITS     = YEAR_BITS - 2;
  localparam int unsigned RECIP_BITS  = 13;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_BITS   = Q4_BITS + RECIP_BITS;
  localparam int unsigned GRP         = (SUM_BITS + 2) / 3;
  // Approximates 2^17 / 25; exact quotient for every quotient input in range.
  localparam logic [RECIP_BITS-1:0] RECIP25 = RECIP_BITS'(5243);

  function automatic logic [2:0] month_offset(logic [3:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // Since 8 leaves 1 modulo 7, octal digits can be summed and folded.
  function automatic logic [2:0] mod7(logic [SUM_BITS-1:0] s);
    logic [GRP*3-1:0] e;
    logic [5:0]       f1;
    logic [3:0]       f2;
    logic [3:0]       f3;
    e  = (GRP*3)'(s);
    f1 = '0;
    for (int g = 0; g < GRP; g++) begin
      f1 = f1 + 6'(e[3*g +: 3]);
    end
    f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
    f3 = 4'(f2[2:0]) + 4'(f2[3]);
    return (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
  endfunction

  logic                 w1_valid_q;
  upd_t                 w1_upd_q;
  year_t                yy_q;
  logic [Q4_BITS-1:0]   q4_q;
  logic [Q4_BITS-1:0]   q100_q;
  logic [5:0]           md_q;
  logic                 out_valid_q;
  rsp_t                 out_q;
  year_t                yy;
  logic [Q4_BITS-1:0]   q4;
  logic [PROD_BITS-1:0] prod;
  logic [SUM_BITS-1:0]  sum;
  logic                 out_ready;
  logic                 w1_ready;

  assign out_ready   = !out_valid_q || rsp_ready_i;
  assign w1_ready    = !w1_valid_q || out_ready;
  assign upd_ready_o = w1_ready;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    yy = upd_i.date.year;
    if (upd_i.date.month < MONTH_MAR && upd_i.date.year != '0) begin
      yy = upd_i.date.year - year_t'(1);
    end
    q4   = yy[YEAR_BITS-1:2];
    prod = PROD_BITS'(q4) * PROD_BITS'(RECIP25);
  end

  assign sum = SUM_BITS'(yy_q) + SUM_BITS'(q4_q) - SUM_BITS'(q100_q)
             + SUM_BITS'(q100_q[Q4_BITS-1:2]) + SUM_BITS'(md_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (w1_ready) begin
        w1_valid_q <= upd_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= w1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_valid_i && w1_ready) begin
      w1_upd_q <= upd_i;
      yy_q     <= yy;
      q4_q     <= q4;
      q100_q   <= Q4_BITS'(prod >> RECIP_SHIFT);
      md_q     <= 6'(month_offset(upd_i.date.month)) + 6'(upd_i.date.day);
    end
    if (w1_valid_q && out_ready) begin
      out_q <= '{date: w1_upd_q.date, weekday: mod7(sum), ok: w1_upd_q.ok,
                 order: w1_upd_q.order};
    end
  end

  `CDC_ASSERT(a_weekday_range, out_valid_q |-> out_q.weekday <= 3'd6, "Weekday out of range.")
  `CDC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q && !w1_valid_q, "Stages not cleared.")

endmodule

>>> hdl/calendar_date_counter_core.sv
// Calendar date counter with day of week.
// The request channel carries a command (set, tick or compare) with a month,
// day and year. Set loads the date only if it is a valid Gregorian date from
// 1900 on, tick advances one day unless the date is December 31 of the
// largest year, and compare orders the stored date against the given one.
// Each request gives exactly one response on the response channel: the
// stored date after the command, its weekday (0 is Sunday), an ok flag and,
// for compare, the order. A response passes an input register, the date
// update register and two weekday registers. One request is accepted in
// every cycle unless all stages are full; the stored date is updated in the
// second stage, so each request sees the effect of the one before it.
// Reset clears all stages and sets the stored date to January 1, 2019.
// When the receiver holds ready low, the response waits in the output register
// and the stages behind it fill up; ready on the request side drops only once
// every stage holds a request.
module calendar_date_counter_core (
  input logic      clk_i,
  input logic      rst_ni,
  cdc_req_if.sink  req_i,
  cdc_rsp_if.source rsp_o
);
  import cdc_pkg::*;

  req_t req;
  logic upd_valid;
  logic upd_ready;
  upd_t upd;
  rsp_t rsp;

  assign req = '{cmd: req_i.cmd, month: req_i.in_month, day: req_i.in_day,
                 year: req_i.in_year};

  cdc_date_update u_date_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .upd_valid_o (upd_valid),
    .upd_ready_i (upd_ready),
    .upd_o       (upd)
  );

  cdc_weekday u_weekday (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_valid_i (upd_valid),
    .upd_ready_o (upd_ready),
    .upd_i       (upd),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign rsp_o.cur_month = rsp.date.month;
  assign rsp_o.cur_day   = rsp.date.day;
  assign rsp_o.cur_year  = rsp.date.year;
  assign rsp_o.weekday   = rsp.weekday;
  assign rsp_o.ok        = rsp.ok;
  assign rsp_o.order     = rsp.order;

endmodule

>>> tb/calendar_date_counter_core_test.sv
`timescale 1ns / 100ps

module calendar_date_counter_core_test;
  import cdc_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam logic [2:0] RESET_WEEKDAY   = 3'd2;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned DRAIN_AT       = 750;
  localparam int unsigned LONG_HOLD_AT   = 300;
  localparam int unsigned LONG_HOLD_LEN  = 64;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t golden;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cdc_req_if req_if ();
  cdc_rsp_if rsp_if ();

  calendar_date_counter_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [3:0] cal_month = RESET_MONTH;
  logic [4:0] cal_day   = RESET_DAY;
  year_t      cal_year  = RESET_YEAR;

  rsp_t          pending_dates[$];
  directed_row_t directed_rows[$];

  int unsigned burst_left;
  int unsigned requests_done;
  int unsigned responses_checked;
  int unsigned mismatches;
  int unsigned sets_seen;
  int unsigned sets_taken;
  int unsigned ticks_seen;
  int unsigned ticks_held;
  int unsigned compares_seen;
  int unsigned unused_seen;

  function automatic bit is_leap_year(input year_t y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input logic [3:0] m, input year_t y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      MONTH_FEB: return is_leap_year(y) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned month_shift(input logic [3:0] m);
    case (m)
      4'd1: return 0;
      4'd2: return 3;
      4'd3: return 2;
      4'd4: return 5;
      4'd5: return 0;
      4'd6: return 3;
      4'd7: return 5;
      4'd8: return 1;
      4'd9: return 4;
      4'd10: return 6;
      4'd11: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic logic [2:0] day_of_week(input logic [3:0] m, input logic [4:0] d,
                                             input year_t y);
    int unsigned yy;
    yy = y;
    if (m < MONTH_MAR && yy > 0) begin
      yy = yy - 1;
    end
    return 3'((yy + yy / 4 - yy / 100 + yy / 400 + month_shift(m) + d) % 7);
  endfunction

  // Applies one request to the shadow date and returns the response it must produce.
  function automatic rsp_t advance_calendar(input req_t r);
    rsp_t res;
    int unsigned len;
    res.ok = 1'b0;
    res.order = ORDER_EQUAL;
    case (r.cmd)
      CMD_SET: begin
        len = days_in_month(r.month, r.year);
        if (r.year >= YEAR_MIN && len != 0 && r.day >= 1 && r.day <= len) begin
          cal_month = r.month;
          cal_day = r.day;
          cal_year = r.year;
          res.ok = 1'b1;
        end
      end
      CMD_TICK: begin
        if (cal_day < days_in_month(cal_month, cal_year)) begin
          cal_day = cal_day + 5'd1;
          res.ok = 1'b1;
        end else if (cal_month < MONTH_DEC) begin
          cal_month = cal_month + 4'd1;
          cal_day = 5'd1;
          res.ok = 1'b1;
        end else if (cal_year < YEAR_MAX) begin
          cal_year = cal_year + 1'b1;
          cal_month = 4'd1;
          cal_day = 5'd1;
          res.ok = 1'b1;
        end
      end
      CMD_COMPARE: begin
        res.ok = 1'b1;
        if (cal_year != r.year) begin
          res.order = (cal_year > r.year) ? ORDER_LATER : ORDER_EARLIER;
        end else if (cal_month != r.month) begin
          res.order = (cal_month > r.month) ? ORDER_LATER : ORDER_EARLIER;
        end else if (cal_day != r.day) begin
          res.order = (cal_day > r.day) ? ORDER_LATER : ORDER_EARLIER;
        end
      end
      default: begin
      end
    endcase
    res.date.month = cal_month;
    res.date.day = cal_day;
    res.date.year = cal_year;
    res.weekday = day_of_week(cal_month, cal_day, cal_year);
    return res;
  endfunction

  function automatic rsp_t reset_date_rsp(input logic ok, input order_e ord);
    rsp_t res;
    res.date.month = RESET_MONTH;
    res.date.day = RESET_DAY;
    res.date.year = RESET_YEAR;
    res.weekday = RESET_WEEKDAY;
    res.ok = ok;
    res.order = ord;
    return res;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int unsigned m, input int unsigned d,
                         input int unsigned y, input bit known, input rsp_t golden);
    directed_row_t row;
    row.req.cmd = cmd;
    row.req.month = 4'(m);
    row.req.day = 5'(d);
    row.req.year = year_t'(y);
    row.known = known;
    row.golden = golden;
    directed_rows.push_back(row);
  endtask

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    r.cmd = CMD_TICK;
    r.month = 4'($urandom);
    r.day = 5'($urandom);
    r.year = year_t'($urandom);
    if (pick < 35) begin
      r.cmd = CMD_TICK;
    end else if (pick < 60) begin
      r.cmd = CMD_SET;
      case ($urandom_range(0, 9))
        0, 1: r.year = year_t'($urandom_range(YEAR_MIN, YEAR_MAX));
        2: r.year = year_t'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
        default: r.year = year_t'($urandom_range(1900, 2500));
      endcase
      r.month = 4'($urandom_range(1, 12));
      len = days_in_month(r.month, r.year);
      if ($urandom_range(0, 1) != 0) begin
        r.day = 5'($urandom_range(len - 1, len));
      end else begin
        r.day = 5'($urandom_range(1, len));
      end
      if ($urandom_range(0, 19) == 0) begin
        r.month = MONTH_DEC;
        r.day = 5'd31;
      end
    end else if (pick < 70) begin
      r.cmd = CMD_SET;
    end else if (pick < 95) begin
      r.cmd = CMD_COMPARE;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        r.month = cal_month;
        r.day = cal_day;
        r.year = cal_year;
      end
      case (pick)
        4: r.year = cal_year + (($urandom_range(0, 1) != 0) ? year_t'(1) : '1);
        5: r.month = cal_month + (($urandom_range(0, 1) != 0) ? 4'd1 : 4'hf);
        6: r.day = cal_day + (($urandom_range(0, 1) != 0) ? 5'd1 : 5'h1f);
        default: begin
        end
      endcase
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  task automatic offer_request(input req_t r, input bit known, input rsp_t golden);
    rsp_t prediction;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left = burst_left - 1;
    req_if.valid <= 1'b1;
    req_if.cmd <= r.cmd;
    req_if.in_month <= r.month;
    req_if.in_day <= r.day;
    req_if.in_year <= r.year;
    do @(posedge clk_i); while (!req_if.ready);
    prediction = advance_calendar(r);
    pending_dates.push_back(known ? golden : prediction);
    requests_done++;
    case (r.cmd)
      CMD_SET: begin
        sets_seen++;
        if (prediction.ok) sets_taken++;
      end
      CMD_TICK: begin
        ticks_seen++;
        if (!prediction.ok) ticks_held++;
      end
      CMD_COMPARE: compares_seen++;
      default: unused_seen++;
    endcase
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
  endtask

  initial begin : request_driver
    rsp_t blank;
    req_t r;
    blank = reset_date_rsp(1'b0, ORDER_EQUAL);
    req_if.valid = 1'b0;
    req_if.cmd = CMD_SET;
    req_if.in_month = '0;
    req_if.in_day = '0;
    req_if.in_year = '0;

    add_row(CMD_COMPARE, 1, 1, 2019, 1, reset_date_rsp(1'b1, ORDER_EQUAL));
    add_row(CMD_UNUSED, 15, 31, 16383, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 0, 10, 2000, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 13, 10, 2000, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 15, 31, 16383, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 6, 0, 2000, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 4, 31, 2000, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 2, 29, 1900, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 1, 1, 1899, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_SET, 1, 1, 0, 1, reset_date_rsp(1'b0, ORDER_EQUAL));
    add_row(CMD_COMPARE, 0, 0, 0, 1, reset_date_rsp(1'b1, ORDER_LATER));
    add_row(CMD_COMPARE, 15, 31, 16383, 1, reset_date_rsp(1'b1, ORDER_EARLIER));
    add_row(CMD_TICK, 0, 0, 0, 0, blank);
    add_row(CMD_SET, 2, 29, 2000, 0, blank);
    add_row(CMD_TICK, 0, 0, 0, 0, blank);
    add_row(CMD_SET, 2, 28, 1900, 0, blank);
    add_row(CMD_TICK, 0, 0, 0, 0, blank);
    add_row(CMD_SET, 1, 1, 1900, 0, blank);
    add_row(CMD_COMPARE, 1, 1, 1900, 0, blank);
    add_row(CMD_SET, 12, 31, 2019, 0, blank);
    add_row(CMD_TICK, 0, 0, 0, 0, blank);
    add_row(CMD_SET, 12, 31, 16383, 0, blank);
    add_row(CMD_TICK, 0, 0, 0, 0, blank);
    add_row(CMD_COMPARE, 12, 31, 16383, 0, blank);
    add_row(CMD_SET, 2, 29, 2024, 0, blank);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].golden);
    end
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == DRAIN_AT) begin
        wait_for_drain();
      end
      r = random_request();
      offer_request(r, 1'b0, blank);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d sets (%0d taken), %0d ticks (%0d held at the end of range),",
             requests_done, sets_seen, sets_taken, ticks_seen, ticks_held);
    $display("%0d compares and %0d unused commands; %0d responses checked, %0d mismatches.",
             compares_seen, unused_seen, responses_checked, mismatches);
    if (mismatches == 0) begin
      $display("calendar_date_counter_core_test passed");
    end else begin
      $display("calendar_date_counter_core_test failed");
    end
    $finish;
  end

  initial begin : response_stall
    int unsigned mode;
    int unsigned seg_len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      if (!long_hold_done && requests_done >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD_LEN) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 20);
        seg_len = $urandom_range(8, 60);
        for (int k = 0; k < seg_len; k++) begin
          case (mode)
            0, 1, 2, 3, 4, 5: rsp_if.ready <= 1'b1;
            6, 7, 8, 9: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            10, 11, 12: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            13, 14, 15: rsp_if.ready <= (k % 4 == 0);
            16, 17, 18: rsp_if.ready <= (k % 2 == 1);
            default: rsp_if.ready <= 1'b0;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      responses_checked++;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected response %0d/%0d/%0d weekday %0d ok %0d order %0d.",
                   rsp_if.cur_month, rsp_if.cur_day, rsp_if.cur_year, rsp_if.weekday,
                   rsp_if.ok, rsp_if.order);
        end
      end else begin
        want = pending_dates.pop_front();
        if (rsp_if.cur_month !== want.date.month || rsp_if.cur_day !== want.date.day ||
            rsp_if.cur_year !== want.date.year || rsp_if.weekday !== want.weekday ||
            rsp_if.ok !== want.ok || rsp_if.order !== want.order) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Response %0d: expected %0d/%0d/%0d wd %0d ok %0d order %0d, got %0d/%0d/%0d wd %0d ok %0d order %0d.",
                     responses_checked, want.date.month, want.date.day, want.date.year,
                     want.weekday, want.ok, want.order, rsp_if.cur_month, rsp_if.cur_day,
                     rsp_if.cur_year, rsp_if.weekday, rsp_if.ok, rsp_if.order);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timed out with %0d responses outstanding.", pending_dates.size());
    $display("calendar_date_counter_core_test failed");
    $finish;
  end

endmodule
